// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the conversion block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// File: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the integer to decimal text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_shift;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic left_one;
        logic negative;
        logic slot_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels for integer input beats and character output beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itoa_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] signed_value;

    modport source (output valid, output signed_value, input ready);
    modport sink   (input valid, input signed_value, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       is_last;

    modport source (output valid, output ascii_char, output is_last, input ready);
    modport sink   (input valid, input ascii_char, input is_last, output ready);
endinterface

`default_nettype wire

// File: rtl/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer for load, binary to BCD conversion, leading-zero skip, sign and digit output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itoa_ctrl
    import itoa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                if (!i_status.conv_done) begin
                    o_cmd.conv_step = 1'b1;
                end else if (i_status.negative) begin
                    n_state = S_SIGN;
                end else begin
                    n_state = S_SKIP;
                end
            end
            S_SIGN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_SKIP;
                end
            end
            S_SKIP: begin
                // Leading zeros are dropped, but the units digit always stays.
                if (i_status.top_zero && !i_status.left_one) begin
                    o_cmd.skip_shift = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.left_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_PROP(a_emit_needs_slot, i_clk, i_rst_n,
        (o_cmd.emit_digit || o_cmd.emit_sign) |-> i_status.slot_free,
        "character issued while the output register is occupied")

    `ASSERT_PROP(a_load_starts_conv, i_clk, i_rst_n,
        o_cmd.load |=> (r_state == S_CONV),
        "accepted beat did not start a conversion")

endmodule

`default_nettype wire

// File: rtl/itoa_dpath.sv
// ----------------------------------------------------------------------------
// itoa_dpath
// Magnitude, double-dabble BCD register, digit counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module itoa_dpath
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_status                        o_status,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [7:0]                        o_out_char,
    output logic                              o_out_last
);

    localparam int ND = (VALUE_BITS * 3) / 10 + 2;
    localparam int BW = 4 * ND;
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int DW = $clog2(ND + 1);

    logic [VALUE_BITS-1:0] r_mag;
    logic [VALUE_BITS-1:0] n_mag;
    logic                  r_neg;
    logic                  n_neg;
    logic [BW-1:0]         r_bcd;
    logic [BW-1:0]         n_bcd;
    logic [BW-1:0]         w_bcd_adj;
    logic [CW-1:0]         r_bit_cnt;
    logic [CW-1:0]         n_bit_cnt;
    logic [DW-1:0]         r_left;
    logic [DW-1:0]         n_left;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [7:0]            r_out_char;
    logic [7:0]            n_out_char;
    logic                  r_out_last;
    logic                  n_out_last;
    logic [3:0]            w_top;
    logic [VALUE_BITS-1:0] w_raw;

    assign w_top = r_bcd[BW-1 -: 4];
    assign w_raw = VALUE_BITS'(i_value);

    // Add-3 correction on every BCD digit before the next shift.
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            w_bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ?
                                  (r_bcd[4*d +: 4] + 4'd3) : r_bcd[4*d +: 4];
        end
    end

    always_comb begin
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_bcd       = r_bcd;
        n_bit_cnt   = r_bit_cnt;
        n_left      = r_left;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.load) begin
            n_neg     = w_raw[VALUE_BITS-1];
            n_mag     = w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
            n_bcd     = '0;
            n_bit_cnt = CW'(VALUE_BITS);
            n_left    = DW'(ND);
        end
        if (i_cmd.conv_step) begin
            n_bcd     = {w_bcd_adj[BW-2:0], r_mag[VALUE_BITS-1]};
            n_mag     = {r_mag[VALUE_BITS-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt - CW'(1);
        end
        if (i_cmd.skip_shift || i_cmd.emit_digit) begin
            n_bcd  = {r_bcd[BW-5:0], 4'h0};
            n_left = r_left - DW'(1);
        end
        if (i_cmd.emit_sign) begin
            n_out_valid = 1'b1;
            n_out_char  = ASCII_MINUS;
            n_out_last  = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_out_valid = 1'b1;
            n_out_char  = ASCII_ZERO + {4'h0, w_top};
            n_out_last  = (r_left == DW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_bcd      <= n_bcd;
        r_bit_cnt  <= n_bit_cnt;
        r_left     <= n_left;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_status.conv_done = (r_bit_cnt == '0);
    assign o_status.top_zero  = (w_top == 4'h0);
    assign o_status.left_one  = (r_left == DW'(1));
    assign o_status.negative  = r_neg;
    assign o_status.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    `ASSERT_PROP(a_char_is_text, i_clk, i_rst_n,
        r_out_valid |-> (r_out_char == ASCII_MINUS ||
                         (r_out_char >= ASCII_ZERO && r_out_char <= ASCII_NINE)),
        "output beat is neither a digit nor a minus sign")

    `ASSERT_NEVER(a_minus_not_last, i_clk, i_rst_n,
        r_out_valid && r_out_char == ASCII_MINUS && r_out_last,
        "minus sign flagged as the final character")

endmodule

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii_top.sv
// After an input beat the magnitude passes bit by bit through the double-dabble
//   loop, then the minus sign (when negative) and the digits follow, most significant first.
// A new integer is taken only after the last digit of the one before is issued;
//   the pace is set by the bit-serial double-dabble loop, by one BCD shift for
//   each of the ND = 3*VALUE_BITS/10 + 2 digits (11 at 32 bits), and by output stalls.
// Reset is synchronous, active low, and clears the state machine and output valid.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_top
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);

    // The controller and the datapath talk only through these two structs.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The controller accepts an input beat only when it is idle. The
    // output register in the datapath lets the final character of one
    // number wait for the sink while the next number is accepted.
    itoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath takes the magnitude, turns it into packed BCD one bit per
    // cycle, then shifts digits out from the most significant end. Leading
    // zeros are shifted away without a beat; the units digit is always sent,
    // so zero gives a single '0'. The most negative value negates to its own
    // bit pattern, which read as unsigned is the correct magnitude.
    itoa_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in.signed_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_char  (o_out.ascii_char),
        .o_out_last  (o_out.is_last)
    );

endmodule

`default_nettype wire

// File: bench/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// Self-checking bench for the signed integer to decimal text converter. A
// short table of directed numbers (zero, single digits, powers of ten, both
// 32-bit extremes) is followed by random numbers of every digit count. Each
// integer beat has its text typed in or spelled out by a local model, and every
// character beat is compared with the oldest character still owed.
// ----------------------------------------------------------------------------

module tb_signed_int_to_decimal_ascii_top;

    import itoa_pkg::*;

    localparam int VALUE_BITS       = 32;
    // Random numbers per idling phase; with the directed table this gives
    // about 230 numbers in total.
    localparam int RANDOM_PER_PHASE = 71;
    // Time given after the last owed character, so that anything still in
    // flight at the end can show up.
    localparam int DRAIN_CYCLES     = 4 * VALUE_BITS;

    // One character of expected text.
    typedef struct packed {
        logic [7:0] ascii_char;
        logic       is_last;
    } t_char_beat;

    // A directed number. An empty text means the local model spells it.
    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        string                        text;
    } t_directed_row;

    logic clk;
    logic rst_n;

    itoa_in_if #(.VALUE_BITS(VALUE_BITS)) in_chan ();
    itoa_out_if                           out_chan ();

    signed_int_to_decimal_ascii_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_chan),
        .o_out  (out_chan)
    );

    // Characters owed by the block, oldest first.
    t_char_beat expected_chars[$];

    int mismatch_count = 0;
    int numbers_sent   = 0;
    int negatives_sent = 0;
    int chars_checked  = 0;

    // Percent of cycles in which the sender holds back or the receiver
    // stalls. The main sequence changes these between phases.
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;

    // Directed numbers. Texts are typed in only where they are obvious; the
    // last six numbers are left to the model.
    t_directed_row directed_rows [18] = '{
        '{32'sd0,           "0"},
        '{32'sd1,           "1"},
        '{-32'sd1,          "-1"},
        '{32'sd9,           "9"},
        '{-32'sd9,          "-9"},
        '{32'sd10,          "10"},
        '{-32'sd10,         "-10"},
        '{32'sd2147483647,  "2147483647"},
        '{32'h8000_0000,    "-2147483648"},
        '{-32'sd2147483647, "-2147483647"},
        '{32'sd1000000000,  "1000000000"},
        '{-32'sd999999999,  "-999999999"},
        '{32'sd12345,       ""},
        '{-32'sd98765,      ""},
        '{32'h5555_5555,    ""},
        '{32'hAAAA_AAAA,    ""},
        '{32'h0000_FFFF,    ""},
        '{32'hFFFF_0000,    ""}
    };

    // 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local model: spells a number as decimal text and queues its characters.
    // The magnitude is taken as an unsigned value, so the most negative input
    // needs no special handling and yields "-2147483648".
    // ------------------------------------------------------------------------
    function automatic void spell_decimal(input logic signed [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [7:0]            digits[$];
        t_char_beat            beat;

        magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        // Digits come out least significant first, so build the text from
        // the front.
        do begin
            digits.push_front(ASCII_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);

        if (value[VALUE_BITS-1]) begin
            beat.ascii_char = ASCII_MINUS;
            beat.is_last    = 1'b0;
            expected_chars.push_back(beat);
        end
        foreach (digits[i]) begin
            beat.ascii_char = digits[i];
            beat.is_last    = (i == digits.size() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // Queues a typed-in text; the flag goes on its final character.
    function automatic void expect_text(input string text);
        t_char_beat beat;

        for (int i = 0; i < text.len(); i++) begin
            beat.ascii_char = text[i];
            beat.is_last    = (i == text.len() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random numbers. Plain random words exercise every input bit, but most
    // of them have ten digits, so the mix also draws numbers of a chosen
    // digit count, values next to powers of ten, and small values around
    // zero.
    // ------------------------------------------------------------------------
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int unsigned           kind;
        int unsigned           ndig;
        int                    small_val;
        longint                low_mag;
        longint                high_mag;
        longint                pow10;
        logic [VALUE_BITS-1:0] magnitude;
        logic                  negative;

        kind     = $urandom_range(0, 9);
        negative = 1'($urandom_range(0, 1));
        if (kind < 3) begin
            return $urandom;
        end
        if (kind == 3) begin
            small_val = int'($urandom_range(0, 40)) - 20;
            return small_val;
        end
        if (kind < 6) begin
            // One below, at, or one above a power of ten.
            pow10 = 1;
            repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
            magnitude = VALUE_BITS'(pow10 + longint'($urandom_range(0, 2)) - 1);
        end else begin
            ndig     = $urandom_range(1, 10);
            pow10    = 1;
            repeat (ndig - 1) pow10 = pow10 * 10;
            low_mag  = (ndig == 1) ? 0 : pow10;
            high_mag = pow10 * 10 - 1;
            if (high_mag > 64'sd2147483647) begin
                high_mag = 64'sd2147483647;
            end
            magnitude = $urandom_range(32'(high_mag), 32'(low_mag));
            // Now and then the one magnitude that only a negative can have.
            if (negative && ndig == 10 && $urandom_range(0, 3) == 0) begin
                magnitude = 32'h8000_0000;
            end
        end
        return negative ? -magnitude : magnitude;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Optional idle cycles come first, then valid is held until the
    // block takes the beat. Each call drives valid once per edge, so a beat
    // that follows another without a gap keeps valid high throughout. The
    // expected text is queued as soon as the beat is taken; the block's
    // latency keeps it well ahead of the first character.
    // ------------------------------------------------------------------------
    task automatic send_number(input logic signed [VALUE_BITS-1:0] value,
                               input string text);
        while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            in_chan.valid <= 1'b0;
            @(posedge clk);
        end
        in_chan.valid        <= 1'b1;
        in_chan.signed_value <= value;
        @(posedge clk);
        while (!in_chan.ready) @(posedge clk);

        if (text.len() == 0) begin
            spell_decimal(value);
        end else begin
            expect_text(text);
        end
        numbers_sent++;
        if (value[VALUE_BITS-1]) begin
            negatives_sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker. Handshake signals are sampled at the edge, before
    // any of this edge's updates land, and ready is then redrawn for the next
    // cycle. Every accepted character beat is matched against the oldest
    // owed character, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : char_sink
        t_char_beat want;

        if (rst_n && out_chan.valid && out_chan.ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                $display("%0t: character beat with nothing owed: char 0x%02h last %0b",
                         $time, out_chan.ascii_char, out_chan.is_last);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (out_chan.ascii_char !== want.ascii_char) begin
                    $display("%0t: ascii_char mismatch: expected 0x%02h actual 0x%02h",
                             $time, want.ascii_char, out_chan.ascii_char);
                    mismatch_count++;
                end
                if (out_chan.is_last !== want.is_last) begin
                    $display("%0t: is_last mismatch: expected %0b actual %0b",
                             $time, want.is_last, out_chan.is_last);
                    mismatch_count++;
                end
            end
        end
        out_chan.ready <= (out_idle_pct == 0) || ($urandom_range(0, 99) >= out_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then three phases of random
    // numbers with different idling, then drain and report.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        // Every block input is known from time zero.
        clk                  = 1'b0;
        rst_n                = 1'b0;
        in_chan.valid        = 1'b0;
        in_chan.signed_value = '0;
        out_chan.ready       = 1'b0;

        // The sender holds back often and the receiver stalls even more, so
        // characters pile up behind a slow sink.
        in_idle_pct  = 36;
        out_idle_pct = 57;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_number(directed_rows[i].value, directed_rows[i].text);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    in_idle_pct  = 36;
                    out_idle_pct = 57;
                end
                1: begin
                    in_idle_pct  = 57;
                    out_idle_pct = 36;
                end
                default: begin
                    // Back-to-back beats on both sides.
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_number(pick_value(), "");
        end
        in_chan.valid <= 1'b0;

        // Wait for every owed character, then give the block time to show
        // anything extra it might still emit.
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d integers (%0d negative), checked %0d character beats.",
                 numbers_sent, negatives_sent, chars_checked);
        $display("Mismatches found: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog. A correct run needs well under a millisecond even with the
    // heaviest stalls, so this only fires on a hang or on characters that
    // never arrive.
    initial begin : watchdog
        #5ms;
        $display("Timeout with %0d characters still owed.", expected_chars.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
